>>> rtl/tss_pkg.sv
// Shared types, constants and helpers for the time-slot task scheduler.
package tss_pkg;

   // Task list limits
   localparam int MAX_TASKS = 16;
   localparam int TASK_CAP  = (MAX_TASKS < 16) ? MAX_TASKS : 16;
   localparam int PTR_W     = 4;
   localparam int CNT_W     = 5;

   // Slot mask
   localparam logic [7:0] FIRST_SLOT = 8'h80;
   localparam logic [7:0] LAST_SLOT  = 8'h01;

   // Command codes
   localparam logic CMD_TIMER = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNTS_PER_MS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MS_PER_SECOND  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_LENGTH_MS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TASK_COUNT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HARD_RECOVERY  = 3'd4;

   // Configuration reset values
   localparam logic [15:0]      RST_COUNTS_PER_MS  = 16'd1000;
   localparam logic [15:0]      RST_MS_PER_SECOND  = 16'd1000;
   localparam logic [15:0]      RST_SLOT_LENGTH_MS = 16'd1;
   localparam logic [CNT_W-1:0] RST_TASK_COUNT     = 5'd16;
   localparam logic             RST_HARD_RECOVERY  = 1'b1;

   typedef struct packed {
      logic [15:0]      counts_per_ms;
      logic [15:0]      ms_per_second;
      logic [15:0]      slot_length_ms;
      logic [CNT_W-1:0] task_count;
      logic             hard_recovery;
   } cfg_type;

   typedef struct packed {
      logic        command;
      logic [15:0] timer_sample;
      logic [7:0]  task_schedule;
   } item_type;

   typedef struct packed {
      logic             run_task;
      logic [PTR_W-1:0] task_number;
      logic [7:0]       current_slot;
      logic             slot_open;
      logic             tick_seen;
      logic [15:0]      millis;
      logic [15:0]      seconds;
      logic             watchdog_request;
   } result_type;

   // Number of tasks in the list: zero acts as one, large values saturate
   function automatic logic [CNT_W-1:0] tasks_in_list(input logic [CNT_W-1:0] count);
      logic [CNT_W-1:0] n;
      n = count;
      if (n == '0) begin
         n = CNT_W'(1);
      end
      if (n > CNT_W'(TASK_CAP)) begin
         n = CNT_W'(TASK_CAP);
      end
      return n;
   endfunction

   function automatic logic one_hot(input logic [7:0] m);
      return (m != 8'h00) && ((m & (m - 8'd1)) == 8'h00);
   endfunction

endpackage

>>> rtl/tss_core.sv
// Scheduler state and single-pass next-state and result logic.
module tss_core (
   input  logic                  clock,
   input  logic                  reset,
   input  tss_pkg::cfg_type      cfg,
   input  logic                  fire,
   input  tss_pkg::item_type     item,
   output tss_pkg::result_type   result
);

   logic [15:0]               last_tick_ff, last_tick_in;
   logic [15:0]               ms_ff, ms_in;
   logic [15:0]               sec_ff, sec_in;
   logic [15:0]               slot_timer_ff, slot_timer_in;
   logic                      enable_ff, enable_in;
   logic [tss_pkg::PTR_W-1:0] ptr_ff, ptr_in;
   logic [7:0]                mask_ff, mask_in;

   logic [15:0]               diff;
   logic                      tick;
   logic [15:0]               ms_inc;
   logic [15:0]               slot_inc;
   logic [tss_pkg::CNT_W-1:0] ptr_inc;
   logic                      last_task;
   logic                      run;
   logic                      wdt;

   always_comb begin
      last_tick_in  = last_tick_ff;
      ms_in         = ms_ff;
      sec_in        = sec_ff;
      slot_timer_in = slot_timer_ff;
      enable_in     = enable_ff;
      ptr_in        = ptr_ff;
      mask_in       = mask_ff;
      run           = 1'b0;
      wdt           = 1'b0;

      diff      = item.timer_sample - last_tick_ff;
      tick      = (item.command == tss_pkg::CMD_TIMER) && (diff >= cfg.counts_per_ms);
      ms_inc    = ms_ff + 16'd1;
      slot_inc  = slot_timer_ff + 16'd1;
      ptr_inc   = {1'b0, ptr_ff} + tss_pkg::CNT_W'(1);
      last_task = ptr_inc >= tss_pkg::tasks_in_list(cfg.task_count);

      if (tick) begin
         last_tick_in = last_tick_ff + cfg.counts_per_ms;
         if (ms_inc >= cfg.ms_per_second) begin
            ms_in  = '0;
            sec_in = sec_ff + 16'd1;
         end else begin
            ms_in = ms_inc;
         end
         if ((slot_inc >= cfg.slot_length_ms) && !enable_ff) begin
            slot_timer_in = '0;
            enable_in     = 1'b1;
         end else begin
            slot_timer_in = slot_inc;
         end
      end else if ((item.command == tss_pkg::CMD_STEP) && enable_ff) begin
         run = (item.task_schedule & mask_ff) != 8'h00;
         if (last_task) begin
            enable_in = 1'b0;
            ptr_in    = '0;
            if (!tss_pkg::one_hot(mask_ff)) begin
               // bad mask: restart at the first slot, flag if hard recovery
               wdt     = cfg.hard_recovery;
               mask_in = tss_pkg::FIRST_SLOT;
            end else if (mask_ff == tss_pkg::LAST_SLOT) begin
               mask_in = tss_pkg::FIRST_SLOT;
            end else begin
               mask_in = mask_ff >> 1;
            end
         end else begin
            ptr_in = ptr_inc[tss_pkg::PTR_W-1:0];
         end
      end

      result.run_task         = run;
      result.task_number      = ptr_ff;
      result.current_slot     = mask_in;
      result.slot_open        = enable_in;
      result.tick_seen        = tick;
      result.millis           = ms_in;
      result.seconds          = sec_in;
      result.watchdog_request = wdt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_tick_ff  <= '0;
         ms_ff         <= '0;
         sec_ff        <= '0;
         slot_timer_ff <= '0;
         enable_ff     <= 1'b1;
         ptr_ff        <= '0;
         mask_ff       <= tss_pkg::FIRST_SLOT;
      end else if (fire) begin
         last_tick_ff  <= last_tick_in;
         ms_ff         <= ms_in;
         sec_ff        <= sec_in;
         slot_timer_ff <= slot_timer_in;
         enable_ff     <= enable_in;
         ptr_ff        <= ptr_in;
         mask_ff       <= mask_in;
      end
   end

`ifndef SYNTHESIS
   a_mask_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(mask_ff))
      else $error("slot mask lost its one-hot form");

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff < tss_pkg::PTR_W'(tss_pkg::TASK_CAP - 1)
      || ptr_ff == tss_pkg::PTR_W'(tss_pkg::TASK_CAP - 1))
      else $error("task pointer beyond task list");

   a_closed_step_holds: assert property (@(posedge clock) disable iff (reset)
      fire && item.command == tss_pkg::CMD_STEP && !enable_ff
      |=> $stable(ptr_ff) && $stable(mask_ff) && !enable_ff)
      else $error("step while closed changed task state");

   a_tick_advances_ref: assert property (@(posedge clock) disable iff (reset)
      fire && tick |=> last_tick_ff == $past(last_tick_ff + cfg.counts_per_ms))
      else $error("tick reference did not advance by one period");
`endif

endmodule

>>> rtl/time_slot_task_scheduler.sv
// Top level of the time-slot task scheduler: handshakes, registers and core.
//
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  command, timer_sample, task_schedule
//  rsp_      out        rsp_valid/rsp_stall  run_task .. watchdog_request
//  csr_      in         csr_write            csr_index, csr_wdata
//
//  One word per cycle while rsp_stall is low; each word passes the input
//  register and then the result register before it appears on rsp_.
//  The input register feeds the core directly, so state updates and the
//  result word come out of one pass of logic into the result register.
//  Synchronous active-high reset restores configuration defaults and state.
//  rsp_stall holds the result register; the input register then fills and
//  req_stall rises until the result word is taken.
module time_slot_task_scheduler (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_command,
   input  logic [15:0]                    req_timer_sample,
   input  logic [7:0]                     req_task_schedule,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_run_task,
   output logic [tss_pkg::PTR_W-1:0]      rsp_task_number,
   output logic [7:0]                     rsp_current_slot,
   output logic                           rsp_slot_open,
   output logic                           rsp_tick_seen,
   output logic [15:0]                    rsp_millis,
   output logic [15:0]                    rsp_seconds,
   output logic                           rsp_watchdog_request,
   // configuration port
   input  logic                           csr_write,
   input  logic [tss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]                    csr_wdata
);

   tss_pkg::cfg_type    cfg_ff;
   logic                in_valid_ff;
   tss_pkg::item_type   in_item_ff;
   logic                rsp_valid_ff;
   tss_pkg::result_type rsp_ff;
   tss_pkg::result_type core_result;
   logic                advance;
   logic                req_accept;

   // Advance the input word into the result register whenever that has room
   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   // Configuration registers; writes to unused indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.counts_per_ms  <= tss_pkg::RST_COUNTS_PER_MS;
         cfg_ff.ms_per_second  <= tss_pkg::RST_MS_PER_SECOND;
         cfg_ff.slot_length_ms <= tss_pkg::RST_SLOT_LENGTH_MS;
         cfg_ff.task_count     <= tss_pkg::RST_TASK_COUNT;
         cfg_ff.hard_recovery  <= tss_pkg::RST_HARD_RECOVERY;
      end else if (csr_write) begin
         case (csr_index)
            tss_pkg::CSR_COUNTS_PER_MS:  cfg_ff.counts_per_ms  <= csr_wdata;
            tss_pkg::CSR_MS_PER_SECOND:  cfg_ff.ms_per_second  <= csr_wdata;
            tss_pkg::CSR_SLOT_LENGTH_MS: cfg_ff.slot_length_ms <= csr_wdata;
            tss_pkg::CSR_TASK_COUNT:
               cfg_ff.task_count <= csr_wdata[tss_pkg::CNT_W-1:0];
            tss_pkg::CSR_HARD_RECOVERY:  cfg_ff.hard_recovery  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Input register: hold while the result side is blocked
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.command       <= req_command;
         in_item_ff.timer_sample  <= req_timer_sample;
         in_item_ff.task_schedule <= req_task_schedule;
      end
   end

   tss_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .fire   (advance),
      .item   (in_item_ff),
      .result (core_result)
   );

   // Result register: load on advance, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_run_task         = rsp_ff.run_task;
   assign rsp_task_number      = rsp_ff.task_number;
   assign rsp_current_slot     = rsp_ff.current_slot;
   assign rsp_slot_open        = rsp_ff.slot_open;
   assign rsp_tick_seen        = rsp_ff.tick_seen;
   assign rsp_millis           = rsp_ff.millis;
   assign rsp_seconds          = rsp_ff.seconds;
   assign rsp_watchdog_request = rsp_ff.watchdog_request;

endmodule

>>> dv/time_slot_task_scheduler_tb.sv
// Self-checking testbench for the time-slot task scheduler, with its own predictor.
`timescale 1ns / 100ps

module time_slot_task_scheduler_tb;

   // Give up on a hung run well past the slowest correct one:
   // about 1100 words under the heaviest idling and stalls.
   localparam int CYCLE_LIMIT = 50000;
   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_PAUSE = 3;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_command = tss_pkg::CMD_TIMER;
   logic [15:0]                   req_timer_sample = '0;
   logic [7:0]                    req_task_schedule = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_run_task;
   logic [tss_pkg::PTR_W-1:0]     rsp_task_number;
   logic [7:0]                    rsp_current_slot;
   logic                          rsp_slot_open;
   logic                          rsp_tick_seen;
   logic [15:0]                   rsp_millis;
   logic [15:0]                   rsp_seconds;
   logic                          rsp_watchdog_request;
   logic                          csr_write = 1'b0;
   logic [tss_pkg::CSR_IDX_W-1:0] csr_index = tss_pkg::CSR_COUNTS_PER_MS;
   logic [15:0]                   csr_wdata = '0;

   time_slot_task_scheduler u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_timer_sample     (req_timer_sample),
      .req_task_schedule    (req_task_schedule),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_run_task         (rsp_run_task),
      .rsp_task_number      (rsp_task_number),
      .rsp_current_slot     (rsp_current_slot),
      .rsp_slot_open        (rsp_slot_open),
      .rsp_tick_seen        (rsp_tick_seen),
      .rsp_millis           (rsp_millis),
      .rsp_seconds          (rsp_seconds),
      .rsp_watchdog_request (rsp_watchdog_request),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // Shadow copy of the register file
   logic [15:0] cfg_counts_per_ms;
   logic [15:0] cfg_ms_per_second;
   logic [15:0] cfg_slot_length;
   logic [4:0]  cfg_task_count;
   logic        cfg_hard_recovery;

   // Shadow copy of the scheduler state
   logic [15:0] tick_ref;
   logic [15:0] ms_cnt;
   logic [15:0] sec_cnt;
   logic [15:0] slot_cnt;
   logic        slot_en;
   int          task_idx;
   logic [7:0]  slot_mask_q;

   tss_pkg::result_type expected_words[$];
   tss_pkg::result_type seen_word;
   tss_pkg::result_type want_word;

   int idle_pct = 0;
   int stall_pct = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int words_sent = 0;
   int ticks_counted = 0;
   int steps_taken = 0;
   int settings_used = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop if the handshakes ever lock up
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, expected_words.size());
         $display("simulation failed");
         $finish;
      end
   end

   // Throttle the result side according to the current phase
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   function automatic string fmt_result(tss_pkg::result_type r);
      return $sformatf("run=%0d task=%0d slot=%h open=%0d tick=%0d ms=%0d s=%0d wdt=%0d",
                       r.run_task, r.task_number, r.current_slot, r.slot_open,
                       r.tick_seen, r.millis, r.seconds, r.watchdog_request);
   endfunction

   task automatic note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   // Compare each result word taken from the block with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_word.run_task         = rsp_run_task;
         seen_word.task_number      = rsp_task_number;
         seen_word.current_slot     = rsp_current_slot;
         seen_word.slot_open        = rsp_slot_open;
         seen_word.tick_seen        = rsp_tick_seen;
         seen_word.millis           = rsp_millis;
         seen_word.seconds          = rsp_seconds;
         seen_word.watchdog_request = rsp_watchdog_request;
         if (expected_words.size() == 0) begin
            note_mismatch({"unexpected word ", fmt_result(seen_word)});
         end else begin
            want_word = expected_words.pop_front();
            if (seen_word !== want_word) begin
               note_mismatch({"expected ", fmt_result(want_word),
                              " got ", fmt_result(seen_word)});
            end
         end
      end
   end

   task automatic reset_shadow;
      cfg_counts_per_ms = tss_pkg::RST_COUNTS_PER_MS;
      cfg_ms_per_second = tss_pkg::RST_MS_PER_SECOND;
      cfg_slot_length   = tss_pkg::RST_SLOT_LENGTH_MS;
      cfg_task_count    = tss_pkg::RST_TASK_COUNT;
      cfg_hard_recovery = tss_pkg::RST_HARD_RECOVERY;
      tick_ref    = '0;
      ms_cnt      = '0;
      sec_cnt     = '0;
      slot_cnt    = '0;
      slot_en     = 1'b1;
      task_idx    = 0;
      slot_mask_q = tss_pkg::FIRST_SLOT;
   endtask

   // Advance the shadow state by one accepted word and return the result it must give
   function automatic tss_pkg::result_type predict_slot_step(tss_pkg::item_type it);
      tss_pkg::result_type r;
      logic [15:0]         elapsed;
      int                  list_len;
      r = '0;
      r.task_number = task_idx[tss_pkg::PTR_W-1:0];
      if (it.command == tss_pkg::CMD_TIMER) begin
         elapsed = it.timer_sample - tick_ref;
         if (elapsed >= cfg_counts_per_ms) begin
            // Move the reference by one period only, so a late sampler catches up
            r.tick_seen = 1'b1;
            tick_ref = tick_ref + cfg_counts_per_ms;
            ms_cnt = ms_cnt + 16'd1;
            if (ms_cnt >= cfg_ms_per_second) begin
               ms_cnt = '0;
               sec_cnt = sec_cnt + 16'd1;
            end
            slot_cnt = slot_cnt + 16'd1;
            if (slot_cnt >= cfg_slot_length && !slot_en) begin
               slot_cnt = '0;
               slot_en = 1'b1;
            end
         end
      end else if (slot_en) begin
         r.run_task = |(it.task_schedule & slot_mask_q);
         list_len = (cfg_task_count == '0) ? 1 : int'(cfg_task_count);
         if (list_len > tss_pkg::TASK_CAP) begin
            list_len = tss_pkg::TASK_CAP;
         end
         task_idx++;
         if (task_idx >= list_len) begin
            // Close the slot and rotate, wrapping at the last; bad masks go to the first
            slot_en = 1'b0;
            task_idx = 0;
            if (slot_mask_q == '0 || (slot_mask_q & (slot_mask_q - 8'd1)) != '0) begin
               r.watchdog_request = cfg_hard_recovery;
               slot_mask_q = 8'h01;
            end
            slot_mask_q = slot_mask_q >> 1;
            if (slot_mask_q == '0) begin
               slot_mask_q = tss_pkg::FIRST_SLOT;
            end
         end
      end
      r.current_slot = slot_mask_q;
      r.slot_open    = slot_en;
      r.millis       = ms_cnt;
      r.seconds      = sec_cnt;
      return r;
   endfunction

   // Offer one word, hold it until accepted, then record its prediction
   task automatic send_word(logic cmd, logic [15:0] sample, logic [7:0] sched);
      tss_pkg::item_type   it;
      tss_pkg::result_type r;
      logic                was_open;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_timer_sample  <= sample;
      req_task_schedule <= sched;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      it.command       = cmd;
      it.timer_sample  = sample;
      it.task_schedule = sched;
      was_open = slot_en;
      r = predict_slot_step(it);
      expected_words.push_back(r);
      words_sent++;
      if (r.tick_seen) begin
         ticks_counted++;
      end
      if (cmd == tss_pkg::CMD_STEP && was_open) begin
         steps_taken++;
      end
   endtask

   // Drop valid and wait until every predicted word has come back
   task automatic drain_block;
      req_valid <= 1'b0;
      while (expected_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   // Write the whole register file while the block is idle
   task automatic set_schedule_config(logic [15:0] cpm, logic [15:0] mps,
                                      logic [15:0] slot_len, logic [4:0] tasks,
                                      logic hard);
      drain_block();
      csr_write <= 1'b1;
      csr_index <= tss_pkg::CSR_COUNTS_PER_MS;
      csr_wdata <= cpm;
      @(posedge clock);
      csr_index <= tss_pkg::CSR_MS_PER_SECOND;
      csr_wdata <= mps;
      @(posedge clock);
      csr_index <= tss_pkg::CSR_SLOT_LENGTH_MS;
      csr_wdata <= slot_len;
      @(posedge clock);
      csr_index <= tss_pkg::CSR_TASK_COUNT;
      csr_wdata <= {11'd0, tasks};
      @(posedge clock);
      csr_index <= tss_pkg::CSR_HARD_RECOVERY;
      csr_wdata <= {15'd0, hard};
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_counts_per_ms = cpm;
      cfg_ms_per_second = mps;
      cfg_slot_length   = slot_len;
      cfg_task_count    = tasks;
      cfg_hard_recovery = hard;
      settings_used++;
   endtask

   // Reset values: threshold edges of the default period and a few steps
   task automatic test_power_on_defaults;
      send_word(tss_pkg::CMD_TIMER, 16'd0, 8'hff);
      send_word(tss_pkg::CMD_TIMER, 16'd999, 8'h00);
      send_word(tss_pkg::CMD_TIMER, 16'd1000, 8'h5a);
      send_word(tss_pkg::CMD_TIMER, 16'hffff, 8'ha5);
      send_word(tss_pkg::CMD_STEP, 16'hffff, 8'hff);
      send_word(tss_pkg::CMD_STEP, 16'h0000, 8'h00);
      send_word(tss_pkg::CMD_STEP, 16'h1234, 8'h80);
   endtask

   // Register extremes: zero period, zero second length, zero slot length,
   // task counts of zero and above the cap, both recovery modes
   task automatic test_register_extremes;
      set_schedule_config(16'd0, 16'd0, 16'd0, 5'd0, 1'b0);
      send_word(tss_pkg::CMD_TIMER, 16'h0000, 8'h12);
      send_word(tss_pkg::CMD_TIMER, 16'h5555, 8'h34);
      send_word(tss_pkg::CMD_STEP, 16'h0f0f, 8'h01);
      send_word(tss_pkg::CMD_STEP, 16'hf0f0, 8'haa);    // refused, slot closed
      send_word(tss_pkg::CMD_TIMER, 16'haaaa, 8'h55);
      send_word(tss_pkg::CMD_STEP, 16'h0001, 8'h40);
      set_schedule_config(16'hffff, 16'hffff, 16'hffff, 5'd17, 1'b1);
      send_word(tss_pkg::CMD_TIMER, tick_ref + 16'hffff, 8'h00);
      send_word(tss_pkg::CMD_TIMER, tick_ref, 8'hff);
      send_word(tss_pkg::CMD_STEP, 16'h8000, 8'h20);
      set_schedule_config(16'd1, 16'd1, 16'd1, 5'd31, 1'b1);
      repeat (4) begin
         send_word(tss_pkg::CMD_TIMER, tick_ref + 16'd1, 8'($urandom_range(255)));
         send_word(tss_pkg::CMD_STEP, 16'($urandom_range(65535)),
                   8'($urandom_range(255)));
      end
   endtask

   // One random word: mostly samples close to the next tick and steps while open
   task automatic random_word;
      int pick;
      int step_share;
      pick = $urandom_range(99);
      step_share = slot_en ? 50 : 15;
      if (pick < step_share) begin
         send_word(tss_pkg::CMD_STEP, 16'($urandom_range(65535)),
                   8'($urandom_range(255)));
      end else if (pick < 80) begin
         send_word(tss_pkg::CMD_TIMER,
                   tick_ref + cfg_counts_per_ms + 16'($urandom_range(2)),
                   8'($urandom_range(255)));
      end else if (pick < 90) begin
         send_word(tss_pkg::CMD_TIMER, tick_ref + cfg_counts_per_ms - 16'd1,
                   8'($urandom_range(255)));
      end else begin
         send_word(tss_pkg::CMD_TIMER, 16'($urandom_range(65535)),
                   8'($urandom_range(255)));
      end
   endtask

   // Random traffic over the four idling modes, with fresh settings per phase
   task automatic test_random_traffic;
      int idle_tab[4];
      int stall_tab[4];
      idle_tab  = '{0, 46, 0, 26};
      stall_tab = '{0, 0, 46, 26};
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 5) begin
            set_schedule_config(16'hffff, 16'hffff, 16'd2, 5'd16, 1'b1);
         end else if (phase == 6) begin
            set_schedule_config(16'd1, 16'd1, 16'd0, 5'd31, 1'b0);
         end else begin
            set_schedule_config(16'($urandom_range(1, 40)), 16'($urandom_range(1, 20)),
                                16'($urandom_range(0, 4)), 5'($urandom_range(1, 6)),
                                1'($urandom_range(1)));
         end
         idle_pct  = idle_tab[phase % 4];
         stall_pct = stall_tab[phase % 4];
         repeat (125) random_word();
      end
      idle_pct  = 0;
      stall_pct = 0;
   endtask

   // Tick on every sample, one second per tick, slot reopening at the first tick if closed
   task automatic test_seconds_run;
      set_schedule_config(16'd0, 16'd1, 16'd0, 5'd1, 1'b0);
      repeat (40) begin
         send_word(tss_pkg::CMD_TIMER, 16'($urandom_range(65535)),
                   8'($urandom_range(255)));
      end
   endtask

   initial begin
      reset_shadow();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_power_on_defaults();
      test_register_extremes();
      test_random_traffic();
      test_seconds_run();
      drain_block();
      if (expected_words.size() != 0) begin
         note_mismatch($sformatf("%0d words never returned", expected_words.size()));
      end
      $display("sent %0d words over %0d register settings: %0d ms ticks, %0d task steps",
               words_sent, settings_used, ticks_counted, steps_taken);
      $display("all idling modes, register extremes and one-second ticks; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
